// ===== sv/pixel_pair_to_bgr_converter_defines.svh =====
// assertion macros for the pixel pair to bgr converter
// no dependencies; included by the files that carry assertions
`ifndef PIXEL_PAIR_TO_BGR_CONVERTER_DEFINES_SVH
`define PIXEL_PAIR_TO_BGR_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS

`define PPBGR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppbgr assertion failed");

`define PPBGR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppbgr assertion failed");

`else

`define PPBGR_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define PPBGR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/ppbgr_pkg.sv =====
// shared types and constants of the pixel pair to bgr converter
// no dependencies
package ppbgr_pkg;

    localparam int SOURCE_W   = 64;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 3;

    typedef enum logic [1:0] {
        KIND_RGB       = 2'd0,
        KIND_PACKED    = 2'd1,
        KIND_COMPONENT = 2'd2
    } source_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_KIND      = 3'd0,
        CFG_BYTES_PER_PIXEL  = 3'd1,
        CFG_RED_OFFSET       = 3'd2,
        CFG_GREEN_OFFSET     = 3'd3,
        CFG_BLUE_OFFSET      = 3'd4,
        CFG_LUMA_OFFSET      = 3'd5,
        CFG_CB_OFFSET        = 3'd6,
        CFG_CHROMA_PER_PIXEL = 3'd7
    } cfg_index_t;

    // how a pixel's three bytes are treated further down
    typedef enum logic [1:0] {
        PIX_PASS = 2'd0,
        PIX_YUV  = 2'd1,
        PIX_ZERO = 2'd2
    } pix_kind_t;

    typedef struct packed {
        logic en_prod;
        logic en_sum;
        logic en_out;
    } stage_en_t;

endpackage

// ===== sv/ppbgr_if.sv =====
// channel interfaces: source pixel pair, bgr pair and config write
// depends on ppbgr_pkg
interface ppbgr_pixel_if
    import ppbgr_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SOURCE_W-1:0] source_bytes;

    modport source (output valid, output source_bytes, input ready);
    modport sink   (input valid, input source_bytes, output ready);
endinterface

interface ppbgr_bgr_if
    import ppbgr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] blue_first;
    logic [BYTE_W-1:0] green_first;
    logic [BYTE_W-1:0] red_first;
    logic [BYTE_W-1:0] blue_second;
    logic [BYTE_W-1:0] green_second;
    logic [BYTE_W-1:0] red_second;

    modport source (output valid, output blue_first, output green_first, output red_first,
                    output blue_second, output green_second, output red_second,
                    input ready);
    modport sink   (input valid, input blue_first, input green_first, input red_first,
                    input blue_second, input green_second, input red_second,
                    output ready);
endinterface

interface ppbgr_cfg_if
    import ppbgr_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/ppbgr_pixel_csc.sv =====
// one pixel through the product, sum and clamp stages of the bt601 conversion
// depends on ppbgr_pkg
module ppbgr_pixel_csc
    import ppbgr_pkg::*;
(
    input  logic              clk,
    input  stage_en_t         stage_en,
    input  pix_kind_t         kind,
    input  logic [BYTE_W-1:0] byte0,
    input  logic [BYTE_W-1:0] byte1,
    input  logic [BYTE_W-1:0] byte2,
    output logic [BYTE_W-1:0] blue,
    output logic [BYTE_W-1:0] green,
    output logic [BYTE_W-1:0] red
);

    function automatic logic [BYTE_W-1:0] clamp_byte(input logic signed [19:0] v);
        logic [BYTE_W-1:0] r;
        if (v[19])
            r = '0;
        else if (|v[18:16])
            r = '1;
        else
            r = v[15:8];
        return r;
    endfunction

    logic signed [8:0]  c_y;
    logic signed [8:0]  d_cb;
    logic signed [8:0]  e_cr;

    pix_kind_t          kind_p_reg;
    logic [3*BYTE_W-1:0] raw_p_reg;
    logic signed [17:0] p_y_reg, p_y_next;
    logic signed [17:0] p_bd_reg, p_bd_next;
    logic signed [15:0] p_gd_reg, p_gd_next;
    logic signed [15:0] p_ge_reg, p_ge_next;
    logic signed [16:0] p_re_reg, p_re_next;

    pix_kind_t          kind_s_reg;
    logic [3*BYTE_W-1:0] raw_s_reg;
    logic signed [19:0] s_b_reg, s_b_next;
    logic signed [19:0] s_g_reg, s_g_next;
    logic signed [19:0] s_r_reg, s_r_next;

    logic [BYTE_W-1:0]  blue_reg, blue_next;
    logic [BYTE_W-1:0]  green_reg, green_next;
    logic [BYTE_W-1:0]  red_reg, red_next;

    always_comb
    begin
        c_y       = $signed({1'b0, byte0}) - 9'sd16;
        d_cb      = $signed({1'b0, byte1}) - 9'sd128;
        e_cr      = $signed({1'b0, byte2}) - 9'sd128;
        p_y_next  = 18'(c_y) * 18'sd298;
        p_bd_next = 18'(d_cb) * 18'sd516;
        p_gd_next = 16'(d_cb) * 16'sd100;
        p_ge_next = 16'(e_cr) * 16'sd208;
        p_re_next = 17'(e_cr) * 17'sd409;
    end

    always_comb
    begin
        s_b_next = 20'(p_y_reg) + 20'(p_bd_reg) + 20'sd128;
        s_g_next = 20'(p_y_reg) - 20'(p_gd_reg) - 20'(p_ge_reg) + 20'sd128;
        s_r_next = 20'(p_y_reg) + 20'(p_re_reg) + 20'sd128;
    end

    always_comb
    begin
        unique case (kind_s_reg)
            PIX_PASS:
            begin
                blue_next  = raw_s_reg[BYTE_W-1:0];
                green_next = raw_s_reg[2*BYTE_W-1:BYTE_W];
                red_next   = raw_s_reg[3*BYTE_W-1:2*BYTE_W];
            end
            PIX_YUV:
            begin
                blue_next  = clamp_byte(s_b_reg);
                green_next = clamp_byte(s_g_reg);
                red_next   = clamp_byte(s_r_reg);
            end
            default:
            begin
                blue_next  = '0;
                green_next = '0;
                red_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stage_en.en_prod)
        begin
            kind_p_reg <= kind;
            raw_p_reg  <= {byte2, byte1, byte0};
            p_y_reg    <= p_y_next;
            p_bd_reg   <= p_bd_next;
            p_gd_reg   <= p_gd_next;
            p_ge_reg   <= p_ge_next;
            p_re_reg   <= p_re_next;
        end
        if (stage_en.en_sum)
        begin
            kind_s_reg <= kind_p_reg;
            raw_s_reg  <= raw_p_reg;
            s_b_reg    <= s_b_next;
            s_g_reg    <= s_g_next;
            s_r_reg    <= s_r_next;
        end
        if (stage_en.en_out)
        begin
            blue_reg  <= blue_next;
            green_reg <= green_next;
            red_reg   <= red_next;
        end
    end

    assign blue  = blue_reg;
    assign green = green_reg;
    assign red   = red_reg;

endmodule

// ===== sv/pixel_pair_to_bgr_converter.sv =====
// top level of the pixel pair to bgr converter: config registers, byte pick, pipeline control
// depends on ppbgr_pkg, ppbgr_if, ppbgr_pixel_csc and the assertion macro header
//
// channel    role    beat
// pixel_in   sink    source_bytes, eight bytes for two adjacent pixels
// bgr_out    source  bgr bytes of both pixels
// cfg        sink    register index and write data, always ready
//
// one beat per cycle sustained while bgr_out is ready
// stages: byte pick, products, sums, clamp into the output register
// each stage moves when it is empty or the one after it moves, so bubbles close up
// a stall on bgr_out holds the pipe without losing or repeating a beat
// rst_n clears the stage valid bits and loads the register defaults
`include "pixel_pair_to_bgr_converter_defines.svh"

module pixel_pair_to_bgr_converter
    import ppbgr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    ppbgr_pixel_if.sink  pixel_in,
    ppbgr_bgr_if.source  bgr_out,
    ppbgr_cfg_if.sink    cfg
);

    function automatic logic [BYTE_W-1:0] byte_at(input logic [SOURCE_W-1:0] w,
                                                  input logic [2:0] idx);
        return w[idx*BYTE_W +: BYTE_W];
    endfunction

    logic [1:0] source_kind_reg;
    logic [2:0] bytes_per_pixel_reg;
    logic [1:0] red_offset_reg;
    logic [1:0] green_offset_reg;
    logic [1:0] blue_offset_reg;
    logic       luma_offset_reg;
    logic [1:0] cb_offset_reg;
    logic       chroma_per_pixel_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;
    stage_en_t stage_en;

    pix_kind_t         kind_next, kind_reg;
    logic [BYTE_W-1:0] a0_next, a1_next, a2_next;
    logic [BYTE_W-1:0] b0_next, b1_next, b2_next;
    logic [BYTE_W-1:0] a0_reg, a1_reg, a2_reg;
    logic [BYTE_W-1:0] b0_reg, b1_reg, b2_reg;

    logic [SOURCE_W-1:0] w;
    logic [2:0]          luma_idx;
    logic [2:0]          cb_idx;
    logic [2:0]          cr_idx;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_kind_reg      <= 2'd0;
            bytes_per_pixel_reg  <= 3'd4;
            red_offset_reg       <= 2'd2;
            green_offset_reg     <= 2'd1;
            blue_offset_reg      <= 2'd0;
            luma_offset_reg      <= 1'b0;
            cb_offset_reg        <= 2'd1;
            chroma_per_pixel_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_index_t'(cfg.index))
                CFG_SOURCE_KIND:      source_kind_reg      <= cfg.data[1:0];
                CFG_BYTES_PER_PIXEL:  bytes_per_pixel_reg  <= cfg.data[2:0];
                CFG_RED_OFFSET:       red_offset_reg       <= cfg.data[1:0];
                CFG_GREEN_OFFSET:     green_offset_reg     <= cfg.data[1:0];
                CFG_BLUE_OFFSET:      blue_offset_reg      <= cfg.data[1:0];
                CFG_LUMA_OFFSET:      luma_offset_reg      <= cfg.data[0];
                CFG_CB_OFFSET:        cb_offset_reg        <= cfg.data[1:0];
                CFG_CHROMA_PER_PIXEL: chroma_per_pixel_reg <= cfg.data[0];
            endcase
        end
    end

    // stage handshake, back to front
    assign adv4 = !v4_reg || bgr_out.ready;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;

    assign pixel_in.ready   = adv1;
    assign stage_en.en_prod = adv2;
    assign stage_en.en_sum  = adv3;
    assign stage_en.en_out  = adv4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= pixel_in.valid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
            if (adv4)
                v4_reg <= v3_reg;
        end
    end

    // byte pick
    always_comb
    begin
        w        = pixel_in.source_bytes;
        luma_idx = {2'b00, luma_offset_reg};
        cb_idx   = {1'b0, cb_offset_reg};
        cr_idx   = {1'b0, 2'(cb_offset_reg + 2'd2)};
        unique case (source_kind_t'(source_kind_reg))
            KIND_RGB:
            begin
                kind_next = PIX_PASS;
                a0_next   = byte_at(w, {1'b0, blue_offset_reg});
                a1_next   = byte_at(w, {1'b0, green_offset_reg});
                a2_next   = byte_at(w, {1'b0, red_offset_reg});
                b0_next   = byte_at(w, 3'(bytes_per_pixel_reg + {1'b0, blue_offset_reg}));
                b1_next   = byte_at(w, 3'(bytes_per_pixel_reg + {1'b0, green_offset_reg}));
                b2_next   = byte_at(w, 3'(bytes_per_pixel_reg + {1'b0, red_offset_reg}));
            end
            KIND_PACKED:
            begin
                kind_next = PIX_YUV;
                a0_next   = byte_at(w, luma_idx);
                a1_next   = byte_at(w, cb_idx);
                a2_next   = byte_at(w, cr_idx);
                b0_next   = byte_at(w, 3'(luma_idx + 3'd2));
                b1_next   = byte_at(w, cb_idx);
                b2_next   = byte_at(w, cr_idx);
            end
            KIND_COMPONENT:
            begin
                kind_next = PIX_YUV;
                a0_next   = w[7:0];
                a1_next   = w[23:16];
                a2_next   = w[31:24];
                b0_next   = w[15:8];
                b1_next   = chroma_per_pixel_reg ? w[39:32] : w[23:16];
                b2_next   = chroma_per_pixel_reg ? w[47:40] : w[31:24];
            end
            default:
            begin
                kind_next = PIX_ZERO;
                a0_next   = '0;
                a1_next   = '0;
                a2_next   = '0;
                b0_next   = '0;
                b1_next   = '0;
                b2_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            kind_reg <= kind_next;
            a0_reg   <= a0_next;
            a1_reg   <= a1_next;
            a2_reg   <= a2_next;
            b0_reg   <= b0_next;
            b1_reg   <= b1_next;
            b2_reg   <= b2_next;
        end
    end

    ppbgr_pixel_csc u_first (
        .clk      (clk),
        .stage_en (stage_en),
        .kind     (kind_reg),
        .byte0    (a0_reg),
        .byte1    (a1_reg),
        .byte2    (a2_reg),
        .blue     (bgr_out.blue_first),
        .green    (bgr_out.green_first),
        .red      (bgr_out.red_first)
    );

    ppbgr_pixel_csc u_second (
        .clk      (clk),
        .stage_en (stage_en),
        .kind     (kind_reg),
        .byte0    (b0_reg),
        .byte1    (b1_reg),
        .byte2    (b2_reg),
        .blue     (bgr_out.blue_second),
        .green    (bgr_out.green_second),
        .red      (bgr_out.red_second)
    );

    assign bgr_out.valid = v4_reg;

    `PPBGR_ASSERT_NEXT(a_in_lands, clk, rst_n, pixel_in.valid && pixel_in.ready, v1_reg)
    `PPBGR_ASSERT_IMPLY(a_full_blocks, clk, rst_n, v1_reg && !adv2, !pixel_in.ready)
    `PPBGR_ASSERT_NEXT(a_sum_holds, clk, rst_n, v2_reg && !adv3, v2_reg)
    `PPBGR_ASSERT_NEXT(a_to_out, clk, rst_n, v3_reg && adv4, bgr_out.valid)

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for pixel_pair_to_bgr_converter: random and directed pixel pairs
// depends on ppbgr_pkg, the channel interfaces in ppbgr_if and the converter rtl
// a scoreboard class predicts each bgr beat from the source bytes and the register copy
module tb
    import ppbgr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] KIND_UNUSED    = 3'd3;
    localparam int         PIPE_LATENCY   = 8;
    localparam int         HOLD_CYCLES    = 200;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         PHASES         = 16;
    localparam int         PHASE_ITEMS    = 50;
    localparam int         STEADY_PHASE   = 5;
    localparam int         HOLD_PHASE     = 8;
    localparam int         PAUSE_PHASE    = 11;
    localparam logic [7:0] CORNER_BYTES [5] = '{8'd0, 8'd16, 8'd128, 8'd235, 8'd255};

    typedef struct packed {
        logic [7:0] blue_first;
        logic [7:0] green_first;
        logic [7:0] red_first;
        logic [7:0] blue_second;
        logic [7:0] green_second;
        logic [7:0] red_second;
    } bgr_pair_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] bpp;
        logic [2:0] red;
        logic [2:0] green;
        logic [2:0] blue;
        logic [2:0] luma;
        logic [2:0] cb;
        logic [2:0] chroma;
    } settings_t;

    localparam settings_t DEFAULTS =
        '{{1'b0, KIND_RGB}, 3'd4, 3'd2, 3'd1, 3'd0, 3'd0, 3'd1, 3'd0};

    class bgr_scoreboard;
        logic [1:0] kind;
        logic [2:0] bpp;
        logic [1:0] red_off;
        logic [1:0] green_off;
        logic [1:0] blue_off;
        logic       luma_off;
        logic [1:0] cb_off;
        logic       chroma_own;
        bgr_pair_t  expected_q[$];
        int         errors;

        function new();
            kind       = KIND_RGB;
            bpp        = 3'd4;
            red_off    = 2'd2;
            green_off  = 2'd1;
            blue_off   = 2'd0;
            luma_off   = 1'b0;
            cb_off     = 2'd1;
            chroma_own = 1'b0;
            errors     = 0;
        endfunction

        function void set_register(cfg_index_t idx, logic [2:0] value);
            case (idx)
                CFG_SOURCE_KIND:      kind = value[1:0];
                CFG_BYTES_PER_PIXEL:  bpp = value;
                CFG_RED_OFFSET:       red_off = value[1:0];
                CFG_GREEN_OFFSET:     green_off = value[1:0];
                CFG_BLUE_OFFSET:      blue_off = value[1:0];
                CFG_LUMA_OFFSET:      luma_off = value[0];
                CFG_CB_OFFSET:        cb_off = value[1:0];
                CFG_CHROMA_PER_PIXEL: chroma_own = value[0];
                default:              ;
            endcase
        endfunction

        function logic [7:0] pick_byte(logic [63:0] w, logic [2:0] idx);
            return w[8*idx +: 8];
        endfunction

        function logic [7:0] clamp_channel(int v);
            int q;
            q = v >>> 8;
            if (q < 0)
                return 8'd0;
            if (q > 255)
                return 8'd255;
            return q[7:0];
        endfunction

        function logic [23:0] yuv_to_bgr(logic [7:0] y, logic [7:0] cb_b, logic [7:0] cr_b);
            int c;
            int d;
            int e;
            c = int'(y) - 16;
            d = int'(cb_b) - 128;
            e = int'(cr_b) - 128;
            return {clamp_channel(298 * c + 516 * d + 128),
                    clamp_channel(298 * c - 100 * d - 208 * e + 128),
                    clamp_channel(298 * c + 409 * e + 128)};
        endfunction

        function void note_input(logic [63:0] w);
            bgr_pair_t  p;
            logic [7:0] cb0;
            logic [7:0] cr0;
            logic [7:0] cb1;
            logic [7:0] cr1;
            p = '0;
            case (kind)
                KIND_RGB:
                begin
                    p.blue_first   = pick_byte(w, 3'(blue_off));
                    p.green_first  = pick_byte(w, 3'(green_off));
                    p.red_first    = pick_byte(w, 3'(red_off));
                    p.blue_second  = pick_byte(w, 3'(bpp + blue_off));
                    p.green_second = pick_byte(w, 3'(bpp + green_off));
                    p.red_second   = pick_byte(w, 3'(bpp + red_off));
                end
                KIND_PACKED:
                begin
                    cb0 = pick_byte(w, {1'b0, cb_off});
                    cr0 = pick_byte(w, {1'b0, 2'(cb_off + 2'd2)});
                    p = {yuv_to_bgr(pick_byte(w, {2'b0, luma_off}), cb0, cr0),
                         yuv_to_bgr(pick_byte(w, {2'b0, luma_off} + 3'd2), cb0, cr0)};
                end
                KIND_COMPONENT:
                begin
                    cb0 = w[23:16];
                    cr0 = w[31:24];
                    cb1 = chroma_own ? w[39:32] : cb0;
                    cr1 = chroma_own ? w[47:40] : cr0;
                    p = {yuv_to_bgr(w[7:0], cb0, cr0), yuv_to_bgr(w[15:8], cb1, cr1)};
                end
                default:
                    p = '0;
            endcase
            expected_q.push_back(p);
        endfunction

        function void compare_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
            if (got_v !== exp_v)
            begin
                $error("%s: expected %0d, actual %0d", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(bgr_pair_t got);
            bgr_pair_t exp_p;
            if (expected_q.size() == 0)
            begin
                $error("bgr beat with no pixel pair pending");
                errors++;
                return;
            end
            exp_p = expected_q.pop_front();
            compare_field("blue_first", exp_p.blue_first, got.blue_first);
            compare_field("green_first", exp_p.green_first, got.green_first);
            compare_field("red_first", exp_p.red_first, got.red_first);
            compare_field("blue_second", exp_p.blue_second, got.blue_second);
            compare_field("green_second", exp_p.green_second, got.green_second);
            compare_field("red_second", exp_p.red_second, got.red_second);
        endfunction
    endclass

    logic clk;
    logic rst_n = 1'b0;
    bit   steady = 1'b0;
    bit   hold_request = 1'b0;

    bgr_scoreboard board;

    ppbgr_pixel_if pix();
    ppbgr_bgr_if   bgr();
    ppbgr_cfg_if   cfg();

    pixel_pair_to_bgr_converter u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel_in (pix),
        .bgr_out  (bgr),
        .cfg      (cfg)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_pair(input logic [63:0] w);
        while (!steady && $urandom_range(99) < 26)
        begin
            pix.valid <= 1'b0;
            @(posedge clk);
        end
        pix.valid        <= 1'b1;
        pix.source_bytes <= w;
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
        board.note_input(w);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (board.expected_q.size() != 0);
    endtask

    task automatic settle();
        pix.valid <= 1'b0;
        wait_drained();
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    task automatic put_register(input cfg_index_t idx, input logic [2:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        board.set_register(idx, value);
    endtask

    task automatic apply_settings(input settings_t s);
        put_register(CFG_SOURCE_KIND, s.kind);
        put_register(CFG_BYTES_PER_PIXEL, s.bpp);
        put_register(CFG_RED_OFFSET, s.red);
        put_register(CFG_GREEN_OFFSET, s.green);
        put_register(CFG_BLUE_OFFSET, s.blue);
        put_register(CFG_LUMA_OFFSET, s.luma);
        put_register(CFG_CB_OFFSET, s.cb);
        put_register(CFG_CHROMA_PER_PIXEL, s.chroma);
        cfg.valid <= 1'b0;
    endtask

    function automatic settings_t random_settings();
        settings_t s;
        s.kind   = ($urandom_range(7) == 0) ? KIND_UNUSED : 3'($urandom_range(2));
        s.bpp    = 3'($urandom_range(7));
        s.red    = 3'($urandom_range(7));
        s.green  = 3'($urandom_range(7));
        s.blue   = 3'($urandom_range(7));
        s.luma   = 3'($urandom_range(7));
        s.cb     = 3'($urandom_range(7));
        s.chroma = 3'($urandom_range(7));
        return s;
    endfunction

    function automatic logic [63:0] random_pair_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        for (int k = 0; k < 8; k++)
            if ($urandom_range(3) == 0)
                w[8*k +: 8] = CORNER_BYTES[$urandom_range(4)];
        return w;
    endfunction

    // sink side: random back-pressure, plus one long hold on request
    initial
    begin
        int        hold_left;
        bgr_pair_t got;
        hold_left = 0;
        bgr.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (bgr.valid && bgr.ready)
            begin
                got = {bgr.blue_first, bgr.green_first, bgr.red_first,
                       bgr.blue_second, bgr.green_second, bgr.red_second};
                board.check_result(got);
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                bgr.ready <= 1'b0;
            end
            else
                bgr.ready <= steady || ($urandom_range(99) >= 26);
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        @(posedge rst_n);
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((pix.valid && pix.ready) || (bgr.valid && bgr.ready) || (cfg.valid && cfg.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        settings_t s;
        board = new();
        pix.valid        <= 1'b0;
        pix.source_bytes <= '0;
        cfg.valid        <= 1'b0;
        cfg.index        <= CFG_SOURCE_KIND;
        cfg.data         <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults after reset
        send_pair(64'h0);
        send_pair('1);
        send_pair(64'h0706050403020100);
        settle();

        apply_settings('{{1'b0, KIND_RGB}, 3'd3, 3'd0, 3'd1, 3'd2, 3'd0, 3'd1, 3'd0});
        send_pair(64'h0706050403020100);
        send_pair(64'hF0E1D2C3B4A59687);
        settle();

        // second pixel index equal to the first, then wrapping past byte 7
        apply_settings('{{1'b0, KIND_RGB}, 3'd0, 3'd3, 3'd3, 3'd3, 3'd0, 3'd1, 3'd0});
        send_pair(64'h0706050403020100);
        settle();
        apply_settings('{{1'b0, KIND_RGB}, 3'd7, 3'd3, 3'd2, 3'd1, 3'd0, 3'd1, 3'd0});
        send_pair(64'h8877665544332211);
        settle();

        apply_settings('{{1'b0, KIND_PACKED}, 3'd4, 3'd2, 3'd1, 3'd0, 3'd0, 3'd1, 3'd0});
        send_pair(64'hA5A5A5A5_FFFFFFFF);
        send_pair(64'h5A5A5A5A_00000000);
        send_pair(64'h00000000_80EB8010);
        send_pair(64'hFFFFFFFF_FF0000FF);
        settle();

        // cr offset wraps to byte 1
        apply_settings('{{1'b0, KIND_PACKED}, 3'd4, 3'd2, 3'd1, 3'd0, 3'd1, 3'd3, 3'd0});
        send_pair(64'h12345678_10FFEB00);
        send_pair(64'h0);
        settle();

        apply_settings('{{1'b0, KIND_COMPONENT}, 3'd4, 3'd2, 3'd1, 3'd0, 3'd0, 3'd1, 3'd0});
        send_pair(64'hFFFF00FF0080EB10);
        send_pair(64'h0000FF00FF0010EB);
        settle();
        apply_settings('{{1'b0, KIND_COMPONENT}, 3'd4, 3'd2, 3'd1, 3'd0, 3'd0, 3'd1, 3'd1});
        send_pair(64'hFFFF00FF0080EB10);
        send_pair(64'h0000FF00FF0010EB);
        settle();

        apply_settings('{KIND_UNUSED, 3'd4, 3'd2, 3'd1, 3'd0, 3'd0, 3'd1, 3'd1});
        send_pair('1);
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       s = '0;
                1:       s = '1;
                2:       s = '{{1'b0, KIND_PACKED}, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd3, 3'd1};
                3:       s = '{{1'b0, KIND_COMPONENT}, 3'd7, 3'd3, 3'd3, 3'd3, 3'd1, 3'd0, 3'd1};
                4:       s = DEFAULTS;
                default: s = random_settings();
            endcase
            apply_settings(s);
            steady = (p == STEADY_PHASE);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == HOLD_PHASE && n == 10)
                    hold_request = 1'b1;
                if (p == PAUSE_PHASE && n == PHASE_ITEMS / 2)
                begin
                    pix.valid <= 1'b0;
                    wait_drained();
                end
                send_pair(random_pair_word());
            end
            steady = 1'b0;
            settle();
        end

        if (board.errors == 0 && board.expected_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
